@@ hdl/esa_pkg.sv @@
// types and constants shared by the encoder step accelerator
package esa_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BANDS = 6;
   localparam int unsigned PACK_W = BANDS * BYTE_W;
   localparam int unsigned IDLE_W = 3;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [IDLE_W-1:0] IDLE_LIMIT = 3'd5;
   localparam logic [BYTE_W-1:0] FINE_LIMIT = 8'd2;

   localparam logic [BYTE_W-1:0] START_STEP_RST = 8'd1;
   localparam logic [BYTE_W-1:0] TIMER_RISE_RST = 8'd4;
   localparam logic [BYTE_W-1:0] TIMER_FALL_RST = 8'd2;
   localparam logic [BYTE_W-1:0] TIMER_CEILING_RST = 8'd200;
   localparam logic [PACK_W-1:0] SPEED_THRESHOLDS_RST = '0;
   localparam logic [PACK_W-1:0] BAND_STEPS_RST = '0;
   localparam logic [BYTE_W-1:0] TICK_WRAP_RST = 8'd100;
   localparam logic [15:0] SAMPLE_POINTS_RST = 16'd12850;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_STEP = 3'd0,
      REG_TIMER_RISE = 3'd1,
      REG_TIMER_FALL = 3'd2,
      REG_TIMER_CEILING = 3'd3,
      REG_SPEED_THRESHOLDS = 3'd4,
      REG_BAND_STEPS = 3'd5,
      REG_TICK_WRAP = 3'd6,
      REG_SAMPLE_POINTS = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REPORT_NONE = 2'd0,
      REPORT_FINE = 2'd1,
      REPORT_COARSE = 2'd2
   } report_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_step;
      logic [BYTE_W-1:0] timer_rise;
      logic [BYTE_W-1:0] timer_fall;
      logic [BYTE_W-1:0] timer_ceiling;
      logic [PACK_W-1:0] speed_thresholds;
      logic [PACK_W-1:0] band_steps;
      logic [BYTE_W-1:0] tick_wrap;
      logic [15:0] sample_points;
   } csr_type;

endpackage

@@ hdl/encoder_step_accelerator_unit.sv @@
// top level of the encoder step accelerator: registers, handshakes and core
//
//   channel | direction | contents
//   req_    | in        | one poll tick: moved, clockwise, value_in
//   rsp_    | out       | one result per tick: value_out, report
//   csr_    | in        | register write: index 0..7, data up to 48 bits
//
// an item is taken into the input register, processed by the core and
// held in the result register; one item per cycle sustained while rsp_
// takes results. the input register refills while a result waits, so
// a stalled rsp_ side backs up at most two items.
// reset clears both valid flags, the dial state and the registers to their
// defaults.
module encoder_step_accelerator_unit
   import esa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // moved, clockwise, value_in[31:0], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // value_out[31:0], report[1:0], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type            csr_ff;
   logic               in_valid_ff;
   logic               in_moved_ff;
   logic               in_cw_ff;
   logic [VALUE_W-1:0] in_value_ff;
   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   report_type         out_report_ff;
   logic               out_free;
   logic               fire;
   logic [VALUE_W-1:0] core_value;
   report_type         core_report;

   assign out_free = !out_valid_ff || rsp_tready;
   assign fire = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_step <= START_STEP_RST;
         csr_ff.timer_rise <= TIMER_RISE_RST;
         csr_ff.timer_fall <= TIMER_FALL_RST;
         csr_ff.timer_ceiling <= TIMER_CEILING_RST;
         csr_ff.speed_thresholds <= SPEED_THRESHOLDS_RST;
         csr_ff.band_steps <= BAND_STEPS_RST;
         csr_ff.tick_wrap <= TICK_WRAP_RST;
         csr_ff.sample_points <= SAMPLE_POINTS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_START_STEP: begin
               csr_ff.start_step <= csr_wdata[BYTE_W-1:0];
            end
            REG_TIMER_RISE: begin
               csr_ff.timer_rise <= csr_wdata[BYTE_W-1:0];
            end
            REG_TIMER_FALL: begin
               csr_ff.timer_fall <= csr_wdata[BYTE_W-1:0];
            end
            REG_TIMER_CEILING: begin
               csr_ff.timer_ceiling <= csr_wdata[BYTE_W-1:0];
            end
            REG_SPEED_THRESHOLDS: begin
               csr_ff.speed_thresholds <= csr_wdata[PACK_W-1:0];
            end
            REG_BAND_STEPS: begin
               csr_ff.band_steps <= csr_wdata[PACK_W-1:0];
            end
            REG_TICK_WRAP: begin
               csr_ff.tick_wrap <= csr_wdata[BYTE_W-1:0];
            end
            REG_SAMPLE_POINTS: begin
               csr_ff.sample_points <= csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_moved_ff <= req_tdata[0];
         in_cw_ff <= req_tdata[1];
         in_value_ff <= req_tdata[VALUE_W+1:2];
      end
   end

   esa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .moved     (in_moved_ff),
      .clockwise (in_cw_ff),
      .value_in  (in_value_ff),
      .csr       (csr_ff),
      .value_out (core_value),
      .report    (core_report)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_value_ff <= core_value;
         out_report_ff <= core_report;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-VALUE_W-2){1'b0}}, out_report_ff, out_value_ff};

endmodule

@@ hdl/esa_step_pick.sv @@
// step size selection from the speed timer and the band thresholds
module esa_step_pick
   import esa_pkg::*;
(
   input  logic [BYTE_W-1:0] timer,
   input  logic [BYTE_W-1:0] start_step,
   input  logic [PACK_W-1:0] speed_thresholds,
   input  logic [PACK_W-1:0] band_steps,
   output logic [BYTE_W-1:0] step
);

   always_comb begin
      step = start_step;
      if (timer >= speed_thresholds[(BANDS-1)*BYTE_W +: BYTE_W]) begin
         step = band_steps[(BANDS-1)*BYTE_W +: BYTE_W];
      end
      // walk down so the lowest matching band wins
      for (int k = BANDS - 2; k >= 0; k--) begin
         if (timer >= speed_thresholds[k*BYTE_W +: BYTE_W] &&
             timer < speed_thresholds[(k+1)*BYTE_W +: BYTE_W]) begin
            step = band_steps[k*BYTE_W +: BYTE_W];
         end
      end
      if (timer != '0 && timer < speed_thresholds[0 +: BYTE_W]) begin
         step = start_step;
      end
   end

endmodule

@@ hdl/esa_core.sv @@
// speed timer, tick counter and idle state with the per item update
module esa_core
   import esa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               moved,
   input  logic               clockwise,
   input  logic [VALUE_W-1:0] value_in,
   input  csr_type            csr,
   output logic [VALUE_W-1:0] value_out,
   output report_type         report
);

   logic [BYTE_W-1:0] timer_ff, timer_in;
   logic [BYTE_W-1:0] tick_ff, tick_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic              ticking_ff, ticking_in;
   logic [BYTE_W-1:0] step;
   logic [BYTE_W-1:0] tick_next;
   logic              sample_hit;

   esa_step_pick u_pick (
      .timer            (timer_ff),
      .start_step       (csr.start_step),
      .speed_thresholds (csr.speed_thresholds),
      .band_steps       (csr.band_steps),
      .step             (step)
   );

   always_comb begin
      ticking_in = ticking_ff | moved;
      idle_in = moved ? '0 : idle_ff;
      tick_next = tick_ff;
      if (ticking_in) begin
         tick_next = (tick_ff < csr.tick_wrap) ? tick_ff + 8'd1 : '0;
      end
      tick_in = tick_next;
      timer_in = timer_ff;
      value_out = value_in;
      report = REPORT_NONE;
      sample_hit = (tick_next == csr.sample_points[7:0]) ||
                   (tick_next == csr.sample_points[15:8]);
      if (moved) begin
         value_out = clockwise ? value_in + {{(VALUE_W-BYTE_W){1'b0}}, step}
                               : value_in - {{(VALUE_W-BYTE_W){1'b0}}, step};
         report = (step <= FINE_LIMIT) ? REPORT_FINE : REPORT_COARSE;
         if (csr.timer_rise <= csr.timer_ceiling &&
             timer_ff < csr.timer_ceiling - csr.timer_rise) begin
            timer_in = timer_ff + csr.timer_rise;
         end
      end else if (sample_hit) begin
         if (timer_ff > csr.timer_fall) begin
            timer_in = timer_ff - csr.timer_fall;
         end
         if (idle_ff < IDLE_LIMIT) begin
            idle_in = idle_ff + 3'd1;
         end
      end
      if (idle_in >= IDLE_LIMIT) begin
         timer_in = '0;
         tick_in = '0;
         ticking_in = 1'b0;
         report = REPORT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         tick_ff <= '0;
         idle_ff <= '0;
         ticking_ff <= 1'b0;
      end else if (fire) begin
         timer_ff <= timer_in;
         tick_ff <= tick_in;
         idle_ff <= idle_in;
         ticking_ff <= ticking_in;
      end
   end

endmodule

@@ tb/sv/encoder_step_accelerator_checker.sv @@
// checker for the encoder step accelerator: tracks registers, predicts each tick, compares results
module encoder_step_accelerator_checker
   import esa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // moved, clockwise, value_in[31:0], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // value_out[31:0], report[1:0], zero pad
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     outstanding
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      report_type         kind;
   } dial_result_type;

   dial_result_type   dial_results_q[$];
   csr_type           regs;
   logic [BYTE_W-1:0] speed_timer;
   logic [BYTE_W-1:0] tick_count;
   logic [IDLE_W-1:0] idle_samples;
   logic              ticking;
   int                mismatches = 0;
   int                waiting_results = 0;

   assign error_count = mismatches;
   assign outstanding = waiting_results;

   task automatic log_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic logic [BYTE_W-1:0] threshold(input int k);
      return regs.speed_thresholds[k*BYTE_W +: BYTE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] band_step();
      logic [BYTE_W-1:0] pick;
      logic              found;
      pick = regs.start_step;
      found = (speed_timer != 0) && (speed_timer < threshold(0));
      for (int k = 0; k < BANDS - 1; k++) begin
         if (!found && speed_timer >= threshold(k) && speed_timer < threshold(k + 1)) begin
            pick = regs.band_steps[k*BYTE_W +: BYTE_W];
            found = 1'b1;
         end
      end
      if (!found && speed_timer >= threshold(BANDS - 1))
         pick = regs.band_steps[(BANDS-1)*BYTE_W +: BYTE_W];
      return pick;
   endfunction

   function automatic dial_result_type advance_dial(input logic moved, input logic cw,
                                                    input logic [VALUE_W-1:0] value);
      dial_result_type   r;
      logic [BYTE_W-1:0] step;
      r.value = value;
      r.kind = REPORT_NONE;
      if (moved) begin
         ticking = 1'b1;
         idle_samples = '0;
      end
      if (ticking)
         tick_count = (tick_count < regs.tick_wrap) ? tick_count + 8'd1 : '0;
      if (moved) begin
         step = band_step();
         r.value = cw ? value + step : value - step;
         r.kind = (step <= FINE_LIMIT) ? REPORT_FINE : REPORT_COARSE;
         if (regs.timer_rise <= regs.timer_ceiling &&
             speed_timer < regs.timer_ceiling - regs.timer_rise)
            speed_timer = speed_timer + regs.timer_rise;
      end else if (tick_count == regs.sample_points[7:0] ||
                   tick_count == regs.sample_points[15:8]) begin
         if (speed_timer > regs.timer_fall)
            speed_timer = speed_timer - regs.timer_fall;
         if (idle_samples < IDLE_LIMIT)
            idle_samples = idle_samples + 3'd1;
      end
      if (idle_samples >= IDLE_LIMIT) begin
         speed_timer = '0;
         tick_count = '0;
         ticking = 1'b0;
         r.kind = REPORT_NONE;
      end
      return r;
   endfunction

   task automatic apply_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_START_STEP:       regs.start_step = data[BYTE_W-1:0];
         REG_TIMER_RISE:       regs.timer_rise = data[BYTE_W-1:0];
         REG_TIMER_FALL:       regs.timer_fall = data[BYTE_W-1:0];
         REG_TIMER_CEILING:    regs.timer_ceiling = data[BYTE_W-1:0];
         REG_SPEED_THRESHOLDS: regs.speed_thresholds = data[PACK_W-1:0];
         REG_BAND_STEPS:       regs.band_steps = data[PACK_W-1:0];
         REG_TICK_WRAP:        regs.tick_wrap = data[BYTE_W-1:0];
         REG_SAMPLE_POINTS:    regs.sample_points = data[15:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      dial_result_type want;
      if (reset) begin
         dial_results_q.delete();
         regs.start_step = START_STEP_RST;
         regs.timer_rise = TIMER_RISE_RST;
         regs.timer_fall = TIMER_FALL_RST;
         regs.timer_ceiling = TIMER_CEILING_RST;
         regs.speed_thresholds = SPEED_THRESHOLDS_RST;
         regs.band_steps = BAND_STEPS_RST;
         regs.tick_wrap = TICK_WRAP_RST;
         regs.sample_points = SAMPLE_POINTS_RST;
         speed_timer = '0;
         tick_count = '0;
         idle_samples = '0;
         ticking = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dial_results_q.size() == 0) begin
               log_mismatch($sformatf("result %h with none expected", rsp_tdata));
            end else begin
               want = dial_results_q.pop_front();
               if (rsp_tdata[0 +: VALUE_W] !== want.value)
                  log_mismatch($sformatf("value_out %h, expected %h",
                                         rsp_tdata[0 +: VALUE_W], want.value));
               if (rsp_tdata[VALUE_W +: 2] !== want.kind)
                  log_mismatch($sformatf("report %0d, expected %0d",
                                         rsp_tdata[VALUE_W +: 2], want.kind));
            end
         end
         if (req_tvalid && req_tready)
            dial_results_q.push_back(advance_dial(req_tdata[0], req_tdata[1],
                                                  req_tdata[2 +: VALUE_W]));
         if (csr_we)
            apply_write(csr_index_type'(csr_index), csr_wdata);
      end
      waiting_results <= dial_results_q.size();
   end

endmodule

@@ tb/sv/tb_encoder_step_accelerator_unit.sv @@
// testbench top for the encoder step accelerator: clock, reset, stimulus and verdict
module tb_encoder_step_accelerator_unit;
   import esa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 90;

   typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     error_count;
   int                     outstanding;
   int                     cycles = 0;
   pace_type               pace = PACE_FULL;

   encoder_step_accelerator_unit dut (.*);

   encoder_step_accelerator_checker dial_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_encoder_step_accelerator_unit: done, errors");
         $finish;
      end
   end

   function automatic int sender_gap_pct();
      return (pace == PACE_SENDER_IDLE) ? 74 : (pace == PACE_BOTH) ? 18 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (pace == PACE_RECEIVER_STALL) ? 74 : (pace == PACE_BOTH) ? 18 : 0;
   endfunction

   always @(posedge clock)
      rsp_tready <= !(int'($urandom_range(0, 99)) < receiver_stall_pct());

   task automatic send_tick(input logic moved, input logic cw, input logic [VALUE_W-1:0] value);
      while (int'($urandom_range(0, 99)) < sender_gap_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({value, cw, moved});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input csr_type s);
      csr_index_type idx;
      idx = idx.first();
      do begin
         csr_we <= 1'b1;
         csr_index <= idx;
         case (idx)
            REG_START_STEP:       csr_wdata <= CSR_DATA_W'(s.start_step);
            REG_TIMER_RISE:       csr_wdata <= CSR_DATA_W'(s.timer_rise);
            REG_TIMER_FALL:       csr_wdata <= CSR_DATA_W'(s.timer_fall);
            REG_TIMER_CEILING:    csr_wdata <= CSR_DATA_W'(s.timer_ceiling);
            REG_SPEED_THRESHOLDS: csr_wdata <= CSR_DATA_W'(s.speed_thresholds);
            REG_BAND_STEPS:       csr_wdata <= CSR_DATA_W'(s.band_steps);
            REG_TICK_WRAP:        csr_wdata <= CSR_DATA_W'(s.tick_wrap);
            default:              csr_wdata <= CSR_DATA_W'(s.sample_points);
         endcase
         @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
   endtask

   function automatic csr_type random_settings();
      csr_type s;
      int      acc;
      s.start_step = BYTE_W'($urandom_range(0, 255));
      s.timer_rise = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                 : BYTE_W'($urandom_range(1, 30));
      s.timer_fall = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                 : BYTE_W'($urandom_range(0, 20));
      s.timer_ceiling = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         s.speed_thresholds = PACK_W'({$urandom(), $urandom()});
      end else begin
         acc = 0;
         for (int k = 0; k < BANDS; k++) begin
            acc += $urandom_range(0, 50);
            s.speed_thresholds[k*BYTE_W +: BYTE_W] = (acc > 255) ? 8'd255 : acc[7:0];
         end
      end
      for (int k = 0; k < BANDS; k++)
         s.band_steps[k*BYTE_W +: BYTE_W] =
            $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 3))
                                 : BYTE_W'($urandom_range(0, 255));
      s.tick_wrap = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                : BYTE_W'($urandom_range(0, 12));
      if ($urandom_range(0, 3) == 0) begin
         s.sample_points = 16'($urandom_range(0, 65535));
      end else begin
         s.sample_points[7:0] = BYTE_W'($urandom_range(0, s.tick_wrap));
         s.sample_points[15:8] = BYTE_W'($urandom_range(0, s.tick_wrap));
      end
      return s;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      csr_type s;
      int      move_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // bands climb with each move, then idle decay until the dial clears
      s.start_step = 8'd5;
      s.timer_rise = 8'd10;
      s.timer_fall = 8'd3;
      s.timer_ceiling = 8'd80;
      s.speed_thresholds = 48'h37_32_28_1E_14_0A;
      s.band_steps = 48'hFF_14_07_03_02_01;
      s.tick_wrap = 8'd2;
      s.sample_points = 16'h0201;
      load_settings(s);
      send_tick(1'b1, 1'b1, 32'hFFFF_FFFF);
      send_tick(1'b1, 1'b0, 32'h0000_0000);
      for (int i = 0; i < 6; i++)
         send_tick(1'b1, i[0], random_value());
      for (int i = 0; i < 10; i++)
         send_tick(1'b0, i[0], i[1] ? 32'hFFFF_FFFF : 32'h0);
      send_tick(1'b1, 1'b0, 32'h0000_0001);
      send_tick(1'b1, 1'b1, 32'hFFFF_FFFC);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         pace = pace_type'(p % 4);
         case (p)
            0: s = '0;
            1: s = '1;
            2: begin
               s.start_step = START_STEP_RST;
               s.timer_rise = TIMER_RISE_RST;
               s.timer_fall = TIMER_FALL_RST;
               s.timer_ceiling = TIMER_CEILING_RST;
               s.speed_thresholds = SPEED_THRESHOLDS_RST;
               s.band_steps = BAND_STEPS_RST;
               s.tick_wrap = TICK_WRAP_RST;
               s.sample_points = SAMPLE_POINTS_RST;
            end
            3: begin
               s = random_settings();
               s.timer_rise = 8'd200;
               s.timer_ceiling = 8'd100;
            end
            default: s = random_settings();
         endcase
         load_settings(s);
         move_pct = 50;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 15 == 0)
               case ($urandom_range(0, 2))
                  0: move_pct = 10;
                  1: move_pct = 50;
                  default: move_pct = 90;
               endcase
            send_tick(int'($urandom_range(0, 99)) < move_pct, 1'($urandom_range(0, 1)),
                      random_value());
         end
         drain();
      end

      if (error_count == 0)
         $display("tb_encoder_step_accelerator_unit: done, clean");
      else
         $display("tb_encoder_step_accelerator_unit: done, errors");
      $finish;
   end

endmodule
